// ===== rtl/bgpls_pkg.sv =====
// Shared types, status codes and the TLV length rule table of the link-state attribute parser.
package bgpls_pkg;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_PARTIAL = 2'd2;
   localparam logic [1:0] ST_UNKNOWN = 2'd3;

   typedef enum logic [1:0] {
      RULE_NONE  = 2'd0,
      RULE_EXACT = 2'd1,
      RULE_MAX   = 2'd2
   } rule_kind_type;

   typedef struct packed {
      logic          known;
      rule_kind_type kind;
      logic [5:0]    limit;
      logic [3:0]    esize;
   } rule_type;

   typedef struct packed {
      logic [15:0] tlv_type;
      logic [15:0] element_index;
      logic [63:0] value;
      logic [3:0]  value_bytes;
      logic [1:0]  status;
      logic        tlv_done;
      logic        msg_done;
   } result_type;

   function automatic rule_type bgpls_lookup(input logic [15:0] code);
      rule_type r;
      r = '{known: 1'b1, kind: RULE_NONE, limit: 6'd0, esize: 4'd0};
      case (code) inside
         16'd263: begin
            r.esize = 4'd2;
         end
         16'd1024, 16'd1094, 16'd1152: begin
            r.kind  = RULE_EXACT;
            r.limit = 6'd1;
            r.esize = 4'd1;
         end
         16'd1025, 16'd1026, 16'd1027, 16'd1097, 16'd1098, 16'd1157: begin
            r.esize = 4'd1;
         end
         16'd1028, 16'd1030, 16'd1088, 16'd1089, 16'd1090, 16'd1155, 16'd1156: begin
            r.kind  = RULE_EXACT;
            r.limit = 6'd4;
            r.esize = 4'd4;
         end
         16'd1029, 16'd1031: begin
            r.kind  = RULE_EXACT;
            r.limit = 6'd16;
            r.esize = 4'd8;
         end
         16'd1091: begin
            r.kind  = RULE_EXACT;
            r.limit = 6'd32;
            r.esize = 4'd4;
         end
         16'd1092: begin
            r.kind  = RULE_MAX;
            r.limit = 6'd4;
         end
         16'd1093: begin
            r.kind  = RULE_EXACT;
            r.limit = 6'd2;
            r.esize = 4'd2;
         end
         16'd1095: begin
            r.kind  = RULE_MAX;
            r.limit = 6'd3;
         end
         16'd1096, 16'd1153: begin
            r.esize = 4'd4;
         end
         16'd1154: begin
            r.esize = 4'd8;
         end
         default: begin
            r.known = 1'b0;
         end
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/bgpls_if.sv =====
// Request and result channel interfaces of the link-state attribute parser.
interface bgpls_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       msg_end;

   modport source (output valid, output data_byte, output msg_end, input ready);
   modport sink (input valid, input data_byte, input msg_end, output ready);
endinterface

interface bgpls_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] tlv_type;
   logic [15:0] element_index;
   logic [63:0] value;
   logic [3:0]  value_bytes;
   logic [1:0]  status;
   logic        tlv_done;
   logic        msg_done;

   modport source (
      output valid, output tlv_type, output element_index, output value,
      output value_bytes, output status, output tlv_done, output msg_done,
      input ready
   );
   modport sink (
      input valid, input tlv_type, input element_index, input value,
      input value_bytes, input status, input tlv_done, input msg_done,
      output ready
   );
endinterface

// ===== rtl/bgpls_parse.sv =====
// Parser state and the per-byte header, length check and element assembly logic.
module bgpls_parse
   import bgpls_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  logic       msg_end,
   output logic       res_valid,
   output result_type res
);

   typedef enum logic [2:0] {
      PH_TYPE_HI = 3'd0,
      PH_TYPE_LO = 3'd1,
      PH_LEN_HI  = 3'd2,
      PH_LEN_LO  = 3'd3,
      PH_VALUE   = 3'd4
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] type_ff, type_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] value_count_ff, value_count_in;
   logic [63:0] accumulator_ff, accumulator_in;
   logic [3:0]  elem_byte_count_ff, elem_byte_count_in;
   logic [15:0] elem_index_ff, elem_index_in;
   logic        discarding_ff, discarding_in;

   rule_type    rule;
   logic [15:0] len_full;
   logic [15:0] vc_sum;
   logic        last;
   logic [63:0] acc_shift;
   logic [3:0]  ebc_sum;
   logic [3:0]  esize;
   logic        len_ok;

   always_comb begin
      rule      = bgpls_lookup(type_ff);
      len_full  = {length_ff[15:8], data_byte};
      vc_sum    = value_count_ff + 16'd1;
      last      = (vc_sum >= length_ff);
      acc_shift = {accumulator_ff[55:0], data_byte};
      ebc_sum   = elem_byte_count_ff + 4'd1;
      esize     = (rule.esize == 4'd0) ? length_ff[3:0] : rule.esize;
      case (rule.kind)
         RULE_EXACT: len_ok = (len_full == {10'd0, rule.limit});
         RULE_MAX:   len_ok = (len_full <= {10'd0, rule.limit});
         default:    len_ok = 1'b1;
      endcase

      phase_in           = phase_ff;
      type_in            = type_ff;
      length_in          = length_ff;
      value_count_in     = value_count_ff;
      accumulator_in     = accumulator_ff;
      elem_byte_count_in = elem_byte_count_ff;
      elem_index_in      = elem_index_ff;
      discarding_in      = discarding_ff;

      res_valid         = 1'b0;
      res.tlv_type      = type_ff;
      res.element_index = elem_index_ff;
      res.value         = '0;
      res.value_bytes   = '0;
      res.status        = ST_OK;
      res.tlv_done      = 1'b1;
      res.msg_done      = msg_end;

      if (!discarding_ff) begin
         case (phase_ff)
            PH_TYPE_HI: begin
               type_in            = {data_byte, 8'h00};
               length_in          = '0;
               value_count_in     = '0;
               accumulator_in     = '0;
               elem_byte_count_in = '0;
               elem_index_in      = '0;
               phase_in           = PH_TYPE_LO;
               res.tlv_type       = {data_byte, 8'h00};
               res.element_index  = '0;
               res.status         = ST_PARTIAL;
               res_valid          = msg_end;
            end
            PH_TYPE_LO: begin
               type_in      = {type_ff[15:8], data_byte};
               phase_in     = PH_LEN_HI;
               res.tlv_type = {type_ff[15:8], data_byte};
               res.status   = ST_PARTIAL;
               res_valid    = msg_end;
            end
            PH_LEN_HI: begin
               length_in  = {data_byte, 8'h00};
               phase_in   = PH_LEN_LO;
               res.status = ST_PARTIAL;
               res_valid  = msg_end;
            end
            PH_LEN_LO: begin
               length_in = len_full;
               res.element_index = '0;
               if (msg_end && (len_full != 16'd0)) begin
                  res.status = ST_PARTIAL;
                  res_valid  = 1'b1;
               end else if (rule.known && !len_ok) begin
                  res.status    = ST_INVALID;
                  res_valid     = 1'b1;
                  discarding_in = 1'b1;
               end else if (len_full == 16'd0) begin
                  res.status = rule.known ? ST_OK : ST_UNKNOWN;
                  res_valid  = 1'b1;
                  phase_in   = PH_TYPE_HI;
               end else begin
                  phase_in = PH_VALUE;
               end
            end
            default: begin
               value_count_in = vc_sum;
               if (last) begin
                  phase_in = PH_TYPE_HI;
               end
               if (msg_end && !last) begin
                  res.status = ST_PARTIAL;
                  res_valid  = 1'b1;
               end else if (!rule.known) begin
                  res.status        = ST_UNKNOWN;
                  res.element_index = '0;
                  res_valid         = last;
               end else if (ebc_sum >= esize) begin
                  res.value          = acc_shift;
                  res.value_bytes    = esize;
                  res.tlv_done       = last;
                  res_valid          = 1'b1;
                  elem_index_in      = elem_index_ff + 16'd1;
                  accumulator_in     = '0;
                  elem_byte_count_in = '0;
               end else begin
                  accumulator_in     = acc_shift;
                  elem_byte_count_in = ebc_sum;
                  res_valid          = last;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && msg_end)) begin
         phase_ff           <= PH_TYPE_HI;
         type_ff            <= '0;
         length_ff          <= '0;
         value_count_ff     <= '0;
         accumulator_ff     <= '0;
         elem_byte_count_ff <= '0;
         elem_index_ff      <= '0;
         discarding_ff      <= 1'b0;
      end else if (step) begin
         phase_ff           <= phase_in;
         type_ff            <= type_in;
         length_ff          <= length_in;
         value_count_ff     <= value_count_in;
         accumulator_ff     <= accumulator_in;
         elem_byte_count_ff <= elem_byte_count_in;
         elem_index_ff      <= elem_index_in;
         discarding_ff      <= discarding_in;
      end
   end

endmodule

// ===== rtl/bgp_ls_attribute_tlv_parser.sv =====
// Top level of the link-state attribute TLV parser with its input and result registers.
//
// The request channel carries one attribute byte per request, in network order,
// with msg_end set on the final byte of the attribute. The result channel
// carries at most one result per request: a TLV element, an empty or trailing
// result, or a status (invalid length, partial message, skipped unknown type).
// A request is taken into an input register; once the output register is free
// or being read, the parser updates its state from that byte and loads any
// result into the output register. The block takes one request every cycle
// while the receiver does not stall.
// The input register takes a new request while the output register still
// holds a result that waits: when the receiver stalls, the parser holds the
// pending byte and the request channel drops ready only once both registers
// are occupied. Reset clears both registers and returns the parser to the
// start of a TLV; any msg_end byte does the same after its result.
module bgp_ls_attribute_tlv_parser
   import bgpls_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   bgpls_req_if.sink   req_ch,
   bgpls_rsp_if.source rsp_ch
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;
   logic       advance;
   logic       res_valid;
   result_type res;

   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ch.ready) begin
         in_valid_in = req_ch.valid;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (advance) begin
         rsp_valid_in = res_valid;
      end
   end

   bgpls_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .msg_end   (in_end_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.data_byte;
         in_end_ff  <= req_ch.msg_end;
      end
      if (advance && res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.tlv_type      = rsp_data_ff.tlv_type;
   assign rsp_ch.element_index = rsp_data_ff.element_index;
   assign rsp_ch.value         = rsp_data_ff.value;
   assign rsp_ch.value_bytes   = rsp_data_ff.value_bytes;
   assign rsp_ch.status        = rsp_data_ff.status;
   assign rsp_ch.tlv_done      = rsp_data_ff.tlv_done;
   assign rsp_ch.msg_done      = rsp_data_ff.msg_done;

endmodule
